// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the tile run-length encoder.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TRE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define TRE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tre_pkg.sv
// Types and constants of the tile run-length encoder.
// Depends on nothing; used by tile_run_length_encoder_unit.
package tre_pkg;

  localparam logic [7:0] RunMax = 8'd255;

  // Result queue: an item can push two results, so the queue holds four.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] tile_x;
    logic [7:0] tile_y;
    logic       last_tile;
  } tile_t;

  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] run_x;
    logic [7:0] run_y;
    logic       last_run;
  } run_t;

endpackage

// File: rtl/core/tile_run_length_encoder_unit.sv
// Tile run-length encoder: input tiles in, (count, x, y) runs out, over valid/stall.
// Depends on tre_pkg and assert_macros.svh.
//
// One tile is taken per clock while input stall is low. Each tile is compared
// with the open run in the cycle it is accepted, and the resulting runs go
// straight into a four-entry result queue, registered behind any results held there.
// A tile closes the run on a new symbol or when the run already counts
// 255; a tile marked last also flushes the open run marked last, so it can push
// two results. Input stall is raised while three or more results are queued;
// with at most one result per tile and an unstalled output the sustained rate is
// one tile per cycle, and the single output port sets the rate at one result per
// cycle otherwise.
`include "assert_macros.svh"

module tile_run_length_encoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tre_pkg::tile_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tre_pkg::run_t  out_data_o
);
  import tre_pkg::*;

  // Open run.
  logic       holding_q, holding_d;
  logic [7:0] held_x_q, held_x_d;
  logic [7:0] held_y_q, held_y_d;
  logic [7:0] held_count_q, held_count_d;

  // Result queue.
  run_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic       in_acc, out_acc;
  logic       close_run;
  logic       push_first, push_last;
  logic [1:0] push_n;
  logic [7:0] run_x, run_y, run_count;
  run_t       first_run, last_run;
  logic [QPtrW-1:0] last_slot;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign close_run = holding_q && ((in_data_i.tile_x != held_x_q) ||
                                   (in_data_i.tile_y != held_y_q) ||
                                   (held_count_q == RunMax));

  // Run that holds the incoming tile.
  always_comb begin
    if (!holding_q || close_run) begin
      run_x     = in_data_i.tile_x;
      run_y     = in_data_i.tile_y;
      run_count = 8'd1;
    end else begin
      run_x     = held_x_q;
      run_y     = held_y_q;
      run_count = held_count_q + 8'd1;
    end
  end

  always_comb begin
    holding_d    = holding_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    held_count_d = held_count_q;
    if (in_acc) begin
      if (in_data_i.last_tile) begin
        holding_d    = 1'b0;
        held_x_d     = '0;
        held_y_d     = '0;
        held_count_d = '0;
      end else begin
        holding_d    = 1'b1;
        held_x_d     = run_x;
        held_y_d     = run_y;
        held_count_d = run_count;
      end
    end
  end

  assign first_run  = '{run_length: held_count_q, run_x: held_x_q, run_y: held_y_q,
                        last_run: 1'b0};
  assign last_run   = '{run_length: run_count, run_x: run_x, run_y: run_y,
                        last_run: 1'b1};
  assign push_first = in_acc && close_run;
  assign push_last  = in_acc && in_data_i.last_tile;
  assign push_n     = {1'b0, push_first} + {1'b0, push_last};
  // The flush result goes behind the closed run when both are pushed.
  assign last_slot  = push_first ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;

  assign wr_ptr_d = wr_ptr_q + QPtrW'(push_n);
  assign rd_ptr_d = out_acc ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
  assign cnt_d    = cnt_q + QCntW'(push_n) - QCntW'(out_acc);

  assign in_stall_o  = cnt_q > QCntW'(QDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q    <= 1'b0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_count_q <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      holding_q    <= holding_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      held_count_q <= held_count_d;
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_first) begin
      queue_q[wr_ptr_q] <= first_run;
    end
    if (push_last) begin
      queue_q[last_slot] <= last_run;
    end
  end

  `TRE_ASSERT(a_queue_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth), "result queue overflow")
  `TRE_ASSERT(a_open_run_nonzero, clk_i, rst_ni,
              !holding_q || (held_count_q != 8'd0), "open run has zero count")
  `TRE_ASSERT_IMPL(a_last_closes, clk_i, rst_ni, in_acc && in_data_i.last_tile,
                   !holding_q, "run still open after last tile")
  `TRE_ASSERT_IMPL(a_pop_only, clk_i, rst_ni, out_acc && !in_acc,
                   cnt_q == $past(cnt_q) - QCntW'(1), "queue count wrong after pop")

endmodule
